>>> design/variable_width_code_unpacker_top_assert.svh
// Assertion macros for the variable-width code unpacker.
// Used by variable_width_code_unpacker_top; needs clk_i and rst_ni in scope.
`ifndef VARIABLE_WIDTH_CODE_UNPACKER_TOP_ASSERT_SVH
`define VARIABLE_WIDTH_CODE_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VWCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vwcu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VWCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vwcu: next-cycle check failed");

`endif

>>> design/vwcu_pkg.sv
// Shared types and constants for the variable-width code unpacker.
// No dependencies.
package vwcu_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned MIN_WIDTH = 8;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CWIDTH_W  = 5;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [CWIDTH_W-1:0] width;
  } vwcu_result_t;

endpackage

>>> design/vwcu_gather.sv
// Bit gathering state and the per-byte step of the code unpacker.
// Depends on vwcu_pkg.
module vwcu_gather #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [vwcu_pkg::BYTE_BITS-1:0] byte_i,
  input  logic                          restart_i,
  input  logic [vwcu_pkg::CFG_W-1:0]    init_width_i,
  output vwcu_pkg::vwcu_result_t        result_o
);
  import vwcu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned SH_W  = $clog2(BYTE_BITS);

  logic [MAX_WIDTH-1:0] partial_q, partial_d;
  logic [CNT_W-1:0]     need_q, need_d;
  logic [CNT_W-1:0]     width_q, width_d;

  logic [CMP_W-1:0]     init_ext;
  logic [CNT_W-1:0]     eff_width;
  logic [MAX_WIDTH+BYTE_BITS-1:0] wide;
  logic [MAX_WIDTH-1:0] full;
  logic [SH_W-1:0]      shift;
  logic [BYTE_BITS-1:0] rem_mask;
  logic                 full_zero;
  logic [CNT_W-1:0]     width_n;
  logic [MAX_WIDTH+VALUE_W-1:0] full_ext;
  logic [CNT_W+CWIDTH_W-1:0]    width_ext;

  // effective initial width, clamped to MIN_WIDTH..MAX_WIDTH
  always_comb begin
    init_ext = CMP_W'(init_width_i);
    if (init_ext < CMP_W'(MIN_WIDTH)) begin
      eff_width = CNT_W'(MIN_WIDTH);
    end else if (init_ext > CMP_W'(MAX_WIDTH)) begin
      eff_width = CNT_W'(MAX_WIDTH);
    end else begin
      eff_width = CNT_W'(init_ext);
    end
  end

  always_comb begin
    wide      = {partial_q, byte_i};
    shift     = SH_W'(CNT_W'(BYTE_BITS) - need_q);
    full      = MAX_WIDTH'(wide >> shift);
    rem_mask  = (BYTE_BITS'(1) << shift) - BYTE_BITS'(1);
    full_zero = (full == '0);
    full_ext  = {{VALUE_W{1'b0}}, full};
    width_ext = {{CWIDTH_W{1'b0}}, width_q};

    width_n = width_q;
    if (full_zero && (width_q < CNT_W'(MAX_WIDTH))) begin
      width_n = width_q + CNT_W'(1);
    end

    result_o       = '0;
    result_o.value = full_ext[VALUE_W-1:0];
    result_o.width = width_ext[CWIDTH_W-1:0];

    if (need_q > CNT_W'(BYTE_BITS)) begin
      partial_d = wide[MAX_WIDTH-1:0];
      need_d    = need_q - CNT_W'(BYTE_BITS);
      width_d   = width_q;
    end else begin
      // code completes in this byte; leftover bits start the next one
      result_o.emit = !full_zero;
      partial_d     = MAX_WIDTH'(byte_i & rem_mask);
      width_d       = width_n;
      need_d        = width_n - CNT_W'(shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      need_q    <= CNT_W'(MIN_WIDTH);
      width_q   <= CNT_W'(MIN_WIDTH);
    end else if (restart_i) begin
      partial_q <= '0;
      need_q    <= eff_width;
      width_q   <= eff_width;
    end else if (step_i) begin
      partial_q <= partial_d;
      need_q    <= need_d;
      width_q   <= width_d;
    end
  end

endmodule

>>> design/variable_width_code_unpacker_top.sv
// Variable-width code unpacker: one byte in, zero or one code out.
// Each byte is registered in in_byte_q, and the code it completes is registered in the output stage.
// Throughput: one byte per cycle, while the output stage is empty or the master side takes its code.
// Reset: async active low; width 8, no pending bits, both stages empty.
// A config write restarts gathering at once at the written width, clamped to 8..MAX_WIDTH.
// Depends on vwcu_pkg, vwcu_gather and variable_width_code_unpacker_top_assert.svh.
`include "variable_width_code_unpacker_top_assert.svh"
module variable_width_code_unpacker_top #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vwcu_pkg::CFG_W-1:0]       cfg_wdata_i,    // initial_width
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [vwcu_pkg::BYTE_BITS-1:0]   s_axis_tdata,   // packed_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [vwcu_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // code_value[15:0], code_width[20:16]
);
  import vwcu_pkg::*;

  logic                 in_valid_q, in_valid_d;
  logic [BYTE_BITS-1:0] in_byte_q;
  logic                 out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]   out_value_q;
  logic [CWIDTH_W-1:0]  out_width_q;
  logic                 advance;
  logic                 in_take;
  vwcu_result_t         res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  vwcu_gather #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_gather (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .restart_i    (cfg_we_i),
    .init_width_i (cfg_wdata_i),
    .result_o     (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res.emit) begin
      out_value_q <= res.value;
      out_width_q <= res.width;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - CWIDTH_W){1'b0}}, out_width_q, out_value_q};

  `VWCU_ASSERT_NOW(a_out_nonzero, out_valid_q, out_value_q != '0 || MAX_WIDTH > VALUE_W)
  `VWCU_ASSERT_NEXT(a_take_fills, in_take, in_valid_q)
  `VWCU_ASSERT_NEXT(a_emit_shows, advance && res.emit, out_valid_q)
  `VWCU_ASSERT_NEXT(a_stall_holds, in_valid_q && !advance, in_valid_q && $stable(in_byte_q))

endmodule

>>> dv/tb_top.sv
// Self-checking bench for variable_width_code_unpacker_top: bytes in, codes out.
// A scoreboard class tracks the gather and width state and checks each code.
// Depends on vwcu_pkg and the design sources.
module tb_top;
  import vwcu_pkg::*;

  localparam int unsigned MAX_W = 16;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned MAX_ERR_LINES = 50;
  localparam int unsigned PHASE_ITEMS = 208;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    bit [VALUE_W-1:0]  value;
    bit [CWIDTH_W-1:0] width;
  } code_t;

  class unpack_tracker;
    code_t             pending_codes[$];
    bit [CWIDTH_W-1:0] start_w;
    bit [CWIDTH_W-1:0] cur_w;
    bit [CWIDTH_W-1:0] need;
    bit [31:0]         partial;
    int                fail_count;

    function new();
      fail_count = 0;
      configure(CFG_RESET);
    endfunction

    function void configure(bit [CFG_W-1:0] w);
      if (w < MIN_WIDTH) start_w = CWIDTH_W'(MIN_WIDTH);
      else if (w > MAX_W) start_w = CWIDTH_W'(MAX_W);
      else start_w = w;
      partial = 0;
      cur_w   = start_w;
      need    = start_w;
    endfunction

    function bit idle();
      return pending_codes.size() == 0;
    endfunction

    // Gather one byte MSB first; a zero code widens, a nonzero one is expected out.
    function void take_byte(bit [BYTE_BITS-1:0] b);
      int    avail;
      int    take;
      bit    emitted;
      code_t c;
      avail   = BYTE_BITS;
      emitted = 1'b0;
      while (avail > 0) begin
        take = (need < avail) ? need : avail;
        avail -= take;
        partial = (partial << take) | ((int'(b) >> avail) & ((1 << take) - 1));
        need = need - CWIDTH_W'(take);
        if (need == 0) begin
          if (partial == 0) begin
            if (cur_w < MAX_W) cur_w++;
          end else if (!emitted) begin
            c.value = partial[VALUE_W-1:0];
            c.width = cur_w;
            pending_codes.push_back(c);
            emitted = 1'b1;
          end
          partial = 0;
          need    = cur_w;
        end
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= MAX_ERR_LINES) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_code(bit [OUT_DATA_W-1:0] d);
      code_t exp_c;
      if (pending_codes.size() == 0) begin
        report($sformatf("code %0h with nothing expected", d));
      end else begin
        exp_c = pending_codes.pop_front();
        if (d[VALUE_W-1:0] != exp_c.value)
          report($sformatf("code value %0h, expected %0h", d[VALUE_W-1:0], exp_c.value));
        if (d[VALUE_W +: CWIDTH_W] != exp_c.width)
          report($sformatf("code width %0d, expected %0d", d[VALUE_W +: CWIDTH_W],
                           exp_c.width));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_BITS-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  unpack_tracker sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            quiet_cycles = 0;
  bit            stream_bits[$];
  int            gen_w;

  bit [BYTE_BITS-1:0] byte_list_reset[] = '{8'hFF, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00,
                                             8'hFF, 8'hFF, 8'hAA, 8'h55};
  bit [BYTE_BITS-1:0] byte_list_max[] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01,
                                           8'h80, 8'h00};

  variable_width_code_unpacker_top #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_code(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Append one code at the stream's current width; zero codes are escapes.
  function automatic void add_code();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 6) v = 0;
    else if (r < 10) v = 1;
    else if (r < 14) v = (1 << gen_w) - 1;
    else if (r < 17) v = 1 << (gen_w - 1);
    else v = $urandom_range(1, (1 << gen_w) - 1);
    for (int i = gen_w - 1; i >= 0; i--) stream_bits.push_back(v[i]);
    if (v == 0 && gen_w < MAX_W) gen_w++;
  endfunction

  function automatic bit [BYTE_BITS-1:0] next_byte();
    bit [BYTE_BITS-1:0] b;
    if ($urandom_range(0, 99) < 15) return BYTE_BITS'($urandom_range(0, 255));
    while (stream_bits.size() < BYTE_BITS) add_code();
    for (int i = 0; i < BYTE_BITS; i++) b = {b[BYTE_BITS-2:0], stream_bits.pop_front()};
    return b;
  endfunction

  task automatic send_byte(input bit [BYTE_BITS-1:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (!sb.idle());
  endtask

  task automatic write_width(input bit [CFG_W-1:0] w);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    sb.configure(w);
    cfg_we_i <= 1'b0;
    stream_bits.delete();
    gen_w = int'(sb.start_w);
  endtask

  initial begin
    bit [CFG_W-1:0] phase_w;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sb            = new();
    gen_w         = int'(sb.start_w);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width 8: plain codes, escapes that widen mid-byte
    foreach (byte_list_reset[i]) send_byte(byte_list_reset[i]);
    // maximum width: escape holds at 16, largest and smallest codes
    write_width(CFG_W'(MAX_W));
    foreach (byte_list_max[i]) send_byte(byte_list_max[i]);
    // below minimum clamps to 8, above maximum clamps to 16
    write_width('0);
    send_byte(8'h01);
    send_byte(8'h00);
    write_width('1);
    send_byte(8'hFF);
    send_byte(8'hFE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 6;  recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: phase_w = CFG_W'(MIN_WIDTH);
        1: phase_w = CFG_W'(MAX_W);
        2: phase_w = '1;
        3: phase_w = '0;
        default: phase_w = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
      endcase
      write_width(phase_w);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_byte(next_byte());
        if (n == PHASE_ITEMS / 2) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES + 2) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.idle())
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
